// ===== src/brent_root_finder_unit_assert.svh =====
// Assertion macros used by the root finder controller.
`ifndef BRENT_ROOT_FINDER_UNIT_ASSERT_SVH
`define BRENT_ROOT_FINDER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define BRF_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/brf_pkg.sv =====
// Shared types, constants and saturating fixed-point functions of the root finder.
package brf_pkg;

    localparam int W = 64;
    localparam int F = 32;
    localparam int ITER_BITS = 8;
    localparam int TOL_BITS = 63;

    typedef logic signed [W-1:0] t_word;
    typedef logic [W-1:0] t_uword;

    localparam t_word WMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(W-1){1'b0}}};
    localparam t_word ONE = t_word'(t_uword'(1) << F);
    localparam t_uword EPS_TWICE = t_uword'(64'd737869762948);

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MAX_ITER = 1'b1;
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(4295);
    localparam logic [ITER_BITS-1:0] MAXIT_RESET = ITER_BITS'(200);

    typedef enum logic [4:0] {
        ST_WAIT, ST_OUT_PREV, ST_OUT_BEST, ST_OUT_FAIL, ST_OUT_ROOT,
        ST_IT_LIMIT, ST_SWAP, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT,
        ST_XM, ST_CONV, ST_SIGN, ST_ACCEPT, ST_FINISH
    } t_state;

    typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_ITER} t_phase;

    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_FPREV, OP_FBEST_HI, OP_FBEST, OP_REBRACKET, OP_SWAP,
        OP_MUL_GO, OP_MUL_WR, OP_DIV_GO, OP_DIV_WR, OP_XM, OP_BISECT, OP_SIGN,
        OP_SHIFT_STEP, OP_FINISH, OP_OUT_PREV, OP_OUT_BEST, OP_OUT_FAIL, OP_OUT_ROOT
    } t_op;

    typedef enum logic [3:0] {
        SEL_TOL, SEL_S, SEL_P_SEC, SEL_QQ, SEL_R, SEL_T1A, SEL_T1B, SEL_T2A,
        SEL_P, SEL_T1C, SEL_Q, SEL_M1, SEL_M2, SEL_M3, SEL_STEP
    } t_sel;

    typedef struct packed {
        t_op  op;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic iter_limit;
        logic start_same;
        logic converged;
        logic interp_ok;
        logic secant;
        logic accept;
        logic mul_done;
        logic div_done;
    } t_stat;

    function automatic t_word sadd(t_word x, t_word y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic t_word ssub(t_word x, t_word y);
        logic signed [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic t_word sneg(t_word x);
        return (x == WMIN) ? WMAX : -x;
    endfunction

    function automatic t_word sabs(t_word x);
        return x[W-1] ? sneg(x) : x;
    endfunction

    function automatic t_uword umag(t_word x);
        return x[W-1] ? (t_uword'(0) - t_uword'(x)) : t_uword'(x);
    endfunction

    function automatic t_word make_signed(t_uword m, logic neg, logic ovf);
        if (neg) begin
            if (ovf || m[W-1]) begin
                return WMIN;
            end
            return t_word'(t_uword'(0) - m);
        end
        if (ovf || m[W-1]) begin
            return WMAX;
        end
        return t_word'(m);
    endfunction

    function automatic logic same_sign(t_word x, t_word y);
        return (x > 0 && y > 0) || (x < 0 && y < 0);
    endfunction

    function automatic t_word half_diff(t_word x, t_word y);
        logic signed [W:0] d;
        logic [W:0] a;
        logic [W:0] h;
        d = {x[W-1], x} - {y[W-1], y};
        a = d[W] ? ((W+1)'(0) - $unsigned(d)) : $unsigned(d);
        h = a >> 1;
        return d[W] ? (t_word'(0) - t_word'(h[W-1:0])) : t_word'(h[W-1:0]);
    endfunction

endpackage

// ===== src/brf_mul.sv =====
// Unsigned multiplier built from four half-width partial products, one half-width multiply per cycle.
module brf_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [brf_pkg::W-1:0]         i_a,
    input  logic [brf_pkg::W-1:0]         i_b,
    output logic                          o_done,
    output logic [2*brf_pkg::W-1:0]       o_prod
);
    import brf_pkg::*;

    localparam int H = W / 2;

    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [2*W-1:0] r_acc;
    logic [1:0]     r_k;
    logic           r_busy;
    logic           r_done;
    logic [H-1:0]   a_part;
    logic [H-1:0]   b_part;
    logic [W-1:0]   pp;
    logic [2*W-1:0] pp_sh;

    always_comb begin
        a_part = r_k[1] ? r_a[W-1:H] : r_a[H-1:0];
        b_part = r_k[0] ? r_b[W-1:H] : r_b[H-1:0];
        pp = W'(a_part) * W'(b_part);
        case (r_k)
            2'd0: pp_sh = {{W{1'b0}}, pp};
            2'd3: pp_sh = {{W{1'b0}}, pp} << W;
            default: pp_sh = {{W{1'b0}}, pp} << H;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== src/brf_div.sv =====
// Restoring divider of magnitudes, one quotient bit per cycle, dividend scaled by the fraction bits.
module brf_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [brf_pkg::W-1:0] i_num,
    input  logic [brf_pkg::W-1:0] i_den,
    output logic                  o_done,
    output logic [brf_pkg::W-1:0] o_quot,
    output logic                  o_ovf
);
    import brf_pkg::*;

    localparam int N = W + F;
    localparam int CW = $clog2(N);

    logic [N-1:0]  r_sh;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic          r_ovf;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          qb;

    always_comb begin
        trial = {r_rem, r_sh[N-1]};
        diff = trial - {1'b0, r_den};
        qb = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(N - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh <= {i_num, {F{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quot <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_sh <= r_sh << 1;
            r_rem <= qb ? diff[W-1:0] : trial[W-1:0];
            r_ovf <= r_ovf | r_quot[W-1];
            r_quot <= {r_quot[W-2:0], qb};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf = r_ovf;
endmodule

// ===== src/brf_dp.sv =====
// Datapath: search state, shared multiplier and divider, result register and configuration.
module brf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brf_pkg::t_cmd                 i_cmd,
    output brf_pkg::t_stat                o_stat,
    input  logic signed [brf_pkg::W-1:0]  i_low_end,
    input  logic signed [brf_pkg::W-1:0]  i_high_end,
    input  logic signed [brf_pkg::W-1:0]  i_function_value,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output logic                          o_finished,
    output logic signed [brf_pkg::W-1:0]  o_point,
    output logic                          o_found
);
    import brf_pkg::*;

    logic [TOL_BITS-1:0]  r_tolerance;
    logic [ITER_BITS-1:0] r_max_iter;
    logic [ITER_BITS-1:0] r_iter;
    t_word r_prev, r_best, r_contra, r_step_now, r_step_before;
    t_word r_f_prev, r_f_best, r_f_contra;
    t_word r_tol1, r_xm, r_s, r_qq, r_rr, r_p, r_q, r_t1, r_t2;
    t_word r_point;
    logic  r_finished, r_found;
    logic  r_mneg, r_dneg, r_dzero;

    t_word m_x, m_y, d_x, d_y, xm2, mres, dres, best_next;
    logic  mul_done, div_done, div_ovf;
    logic [2*W-1:0] prod;
    t_uword quot;

    always_comb begin
        xm2 = sadd(r_xm, r_xm);
        m_x = r_best;
        m_y = t_word'(EPS_TWICE);
        d_x = r_f_best;
        d_y = r_f_prev;
        case (i_cmd.sel)
            SEL_S:     begin d_x = r_f_best; d_y = r_f_prev; end
            SEL_QQ:    begin d_x = r_f_prev; d_y = r_f_contra; end
            SEL_R:     begin d_x = r_f_best; d_y = r_f_contra; end
            SEL_STEP:  begin d_x = r_p; d_y = r_q; end
            SEL_P_SEC: begin m_x = xm2; m_y = r_s; end
            SEL_T1A:   begin m_x = xm2; m_y = r_qq; end
            SEL_T1B:   begin m_x = r_t1; m_y = ssub(r_qq, r_rr); end
            SEL_T2A:   begin m_x = ssub(r_best, r_prev); m_y = ssub(r_rr, ONE); end
            SEL_P:     begin m_x = r_s; m_y = ssub(r_t1, r_t2); end
            SEL_T1C:   begin m_x = ssub(r_qq, ONE); m_y = ssub(r_rr, ONE); end
            SEL_Q:     begin m_x = r_t1; m_y = ssub(r_s, ONE); end
            SEL_M1:    begin m_x = sadd(xm2, r_xm); m_y = r_q; end
            SEL_M2:    begin m_x = r_tol1; m_y = r_q; end
            SEL_M3:    begin m_x = r_step_before; m_y = r_q; end
            default:   begin m_x = r_best; m_y = t_word'(EPS_TWICE); end
        endcase
    end

    brf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL_GO),
        .i_a     (umag(m_x)),
        .i_b     (umag(m_y)),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    brf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_GO),
        .i_num   (umag(d_x)),
        .i_den   (umag(d_y)),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_ovf   (div_ovf)
    );

    always_comb begin
        mres = make_signed(prod[F+W-1:F], r_mneg, |prod[2*W-1:F+W]);
        dres = r_dzero ? t_word'(0) : make_signed(quot, r_dneg, div_ovf);
        if (sabs(r_step_now) > r_tol1) begin
            best_next = sadd(r_best, r_step_now);
        end else begin
            best_next = sadd(r_best, r_xm[W-1] ? -r_tol1 : r_tol1);
        end
    end

    always_comb begin
        o_stat.iter_limit = (r_iter >= r_max_iter);
        o_stat.start_same = same_sign(r_f_prev, i_function_value);
        o_stat.converged = (sabs(r_xm) <= r_tol1) || (r_f_best == t_word'(0));
        o_stat.interp_ok = (sabs(r_step_before) >= r_tol1) && (umag(r_f_prev) > umag(r_f_best));
        o_stat.secant = (r_prev == r_contra);
        o_stat.accept = sadd(r_p, r_p) < ((r_t1 < r_t2) ? r_t1 : r_t2);
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
            r_max_iter <= MAXIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TOLERANCE) begin
                r_tolerance <= i_cfg_data[TOL_BITS-1:0];
            end else if (i_cfg_index == CFG_MAX_ITER) begin
                r_max_iter <= i_cfg_data[ITER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_prev <= i_low_end;
                r_best <= i_high_end;
                r_contra <= i_high_end;
                r_step_now <= '0;
                r_step_before <= '0;
                r_f_prev <= '0;
                r_f_best <= '0;
                r_f_contra <= '0;
                r_iter <= '0;
            end
            OP_FPREV: r_f_prev <= i_function_value;
            OP_FBEST_HI: begin
                r_f_best <= i_function_value;
                r_f_contra <= i_function_value;
            end
            OP_FBEST: r_f_best <= i_function_value;
            OP_REBRACKET: begin
                if (same_sign(r_f_best, r_f_contra)) begin
                    r_contra <= r_prev;
                    r_f_contra <= r_f_prev;
                    r_step_now <= ssub(r_best, r_prev);
                    r_step_before <= ssub(r_best, r_prev);
                end
            end
            OP_SWAP: begin
                if (umag(r_f_contra) < umag(r_f_best)) begin
                    r_prev <= r_best;
                    r_best <= r_contra;
                    r_contra <= r_best;
                    r_f_prev <= r_f_best;
                    r_f_best <= r_f_contra;
                    r_f_contra <= r_f_best;
                end
            end
            OP_MUL_GO: r_mneg <= m_x[W-1] ^ m_y[W-1];
            OP_DIV_GO: begin
                r_dneg <= d_x[W-1] ^ d_y[W-1];
                r_dzero <= (d_x == t_word'(0));
            end
            OP_MUL_WR: begin
                case (i_cmd.sel)
                    SEL_TOL: r_tol1 <= sadd(t_word'(prod[2*W-1:W]),
                                            t_word'({1'b0, r_tolerance[TOL_BITS-1:1]}));
                    SEL_P_SEC: begin
                        r_p <= mres;
                        r_q <= ssub(ONE, r_s);
                    end
                    SEL_T1A, SEL_T1B, SEL_T1C, SEL_M1: r_t1 <= mres;
                    SEL_T2A: r_t2 <= mres;
                    SEL_P: r_p <= mres;
                    SEL_Q: r_q <= mres;
                    SEL_M2: r_t1 <= ssub(r_t1, sabs(mres));
                    SEL_M3: r_t2 <= sabs(mres);
                    default: ;
                endcase
            end
            OP_DIV_WR: begin
                case (i_cmd.sel)
                    SEL_S: r_s <= dres;
                    SEL_QQ: r_qq <= dres;
                    SEL_R: r_rr <= dres;
                    SEL_STEP: r_step_now <= dres;
                    default: ;
                endcase
            end
            OP_XM: r_xm <= half_diff(r_contra, r_best);
            OP_BISECT: begin
                r_step_now <= r_xm;
                r_step_before <= r_xm;
            end
            OP_SIGN: begin
                if (r_p > 0) begin
                    r_q <= sneg(r_q);
                end
                r_p <= sabs(r_p);
            end
            OP_SHIFT_STEP: r_step_before <= r_step_now;
            OP_FINISH: begin
                r_prev <= r_best;
                r_f_prev <= r_f_best;
                r_best <= best_next;
                r_iter <= r_iter + ITER_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_OUT_PREV: begin
                r_point <= r_prev;
                r_finished <= 1'b0;
                r_found <= 1'b0;
            end
            OP_OUT_BEST: begin
                r_point <= r_best;
                r_finished <= 1'b0;
                r_found <= 1'b0;
            end
            OP_OUT_FAIL: begin
                r_point <= '0;
                r_finished <= 1'b1;
                r_found <= 1'b0;
            end
            OP_OUT_ROOT: begin
                r_point <= r_best;
                r_finished <= 1'b1;
                r_found <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_point = r_point;
    assign o_finished = r_finished;
    assign o_found = r_found;
endmodule

// ===== src/brf_ctrl.sv =====
// Controller: handshakes, search phase and the step sequence of one iteration.
`include "brent_root_finder_unit_assert.svh"
module brf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_kind,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  brf_pkg::t_stat  i_stat,
    output brf_pkg::t_cmd   o_cmd
);
    import brf_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_sel   r_sel, n_sel;
    logic   r_m_tvalid, n_m_tvalid;
    logic   s_acc;
    logic   out_free;
    logic   out_issue;

    assign s_acc = i_s_tvalid && (r_state == ST_WAIT);
    assign out_free = !r_m_tvalid || i_m_tready;
    assign out_issue = out_free && (r_state == ST_OUT_PREV || r_state == ST_OUT_BEST ||
                                    r_state == ST_OUT_FAIL || r_state == ST_OUT_ROOT);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_sel = r_sel;
        n_m_tvalid = (r_m_tvalid && !i_m_tready) || out_issue;
        case (r_state)
            ST_WAIT: begin
                if (s_acc) begin
                    if (!i_kind) begin
                        n_phase = PH_LO;
                        n_state = ST_OUT_PREV;
                    end else begin
                        case (r_phase)
                            PH_LO: begin
                                n_phase = PH_HI;
                                n_state = ST_OUT_BEST;
                            end
                            PH_HI: n_state = i_stat.start_same ? ST_OUT_FAIL : ST_IT_LIMIT;
                            PH_ITER: n_state = ST_IT_LIMIT;
                            default: n_state = ST_OUT_FAIL;
                        endcase
                    end
                end
            end
            ST_OUT_PREV, ST_OUT_BEST: if (out_free) n_state = ST_WAIT;
            ST_OUT_FAIL, ST_OUT_ROOT: begin
                if (out_free) begin
                    n_state = ST_WAIT;
                    n_phase = PH_IDLE;
                end
            end
            ST_IT_LIMIT: n_state = i_stat.iter_limit ? ST_OUT_FAIL : ST_SWAP;
            ST_SWAP: begin
                n_state = ST_MUL_GO;
                n_sel = SEL_TOL;
            end
            ST_MUL_GO: n_state = ST_MUL_WAIT;
            ST_DIV_GO: n_state = ST_DIV_WAIT;
            ST_MUL_WAIT, ST_DIV_WAIT: begin
                if ((r_state == ST_MUL_WAIT && i_stat.mul_done) ||
                    (r_state == ST_DIV_WAIT && i_stat.div_done)) begin
                    n_state = ST_MUL_GO;
                    case (r_sel)
                        SEL_TOL: n_state = ST_XM;
                        SEL_S: begin
                            if (i_stat.secant) begin
                                n_sel = SEL_P_SEC;
                            end else begin
                                n_state = ST_DIV_GO;
                                n_sel = SEL_QQ;
                            end
                        end
                        SEL_QQ: begin
                            n_state = ST_DIV_GO;
                            n_sel = SEL_R;
                        end
                        SEL_R: n_sel = SEL_T1A;
                        SEL_T1A: n_sel = SEL_T1B;
                        SEL_T1B: n_sel = SEL_T2A;
                        SEL_T2A: n_sel = SEL_P;
                        SEL_P: n_sel = SEL_T1C;
                        SEL_T1C: n_sel = SEL_Q;
                        SEL_Q, SEL_P_SEC: n_state = ST_SIGN;
                        SEL_M1: n_sel = SEL_M2;
                        SEL_M2: n_sel = SEL_M3;
                        SEL_M3: n_state = ST_ACCEPT;
                        SEL_STEP: n_state = ST_FINISH;
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_XM: n_state = ST_CONV;
            ST_CONV: begin
                if (i_stat.converged) begin
                    n_state = ST_OUT_ROOT;
                end else if (i_stat.interp_ok) begin
                    n_state = ST_DIV_GO;
                    n_sel = SEL_S;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SIGN: begin
                n_state = ST_MUL_GO;
                n_sel = SEL_M1;
            end
            ST_ACCEPT: begin
                if (i_stat.accept) begin
                    n_state = ST_DIV_GO;
                    n_sel = SEL_STEP;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_OUT_BEST;
                n_phase = PH_ITER;
            end
            default: n_state = ST_WAIT;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        o_cmd.sel = r_sel;
        o_s_tready = (r_state == ST_WAIT);
        case (r_state)
            ST_WAIT: begin
                if (s_acc) begin
                    if (!i_kind) begin
                        o_cmd.op = OP_START;
                    end else begin
                        case (r_phase)
                            PH_LO: o_cmd.op = OP_FPREV;
                            PH_HI: o_cmd.op = OP_FBEST_HI;
                            PH_ITER: o_cmd.op = OP_FBEST;
                            default: o_cmd.op = OP_NONE;
                        endcase
                    end
                end
            end
            ST_OUT_PREV: if (out_free) o_cmd.op = OP_OUT_PREV;
            ST_OUT_BEST: if (out_free) o_cmd.op = OP_OUT_BEST;
            ST_OUT_FAIL: if (out_free) o_cmd.op = OP_OUT_FAIL;
            ST_OUT_ROOT: if (out_free) o_cmd.op = OP_OUT_ROOT;
            ST_IT_LIMIT: if (!i_stat.iter_limit) o_cmd.op = OP_REBRACKET;
            ST_SWAP: o_cmd.op = OP_SWAP;
            ST_MUL_GO: o_cmd.op = OP_MUL_GO;
            ST_DIV_GO: o_cmd.op = OP_DIV_GO;
            ST_MUL_WAIT: if (i_stat.mul_done) o_cmd.op = OP_MUL_WR;
            ST_DIV_WAIT: if (i_stat.div_done) o_cmd.op = OP_DIV_WR;
            ST_XM: o_cmd.op = OP_XM;
            ST_CONV: begin
                if (!i_stat.converged && !i_stat.interp_ok) o_cmd.op = OP_BISECT;
            end
            ST_SIGN: o_cmd.op = OP_SIGN;
            ST_ACCEPT: o_cmd.op = i_stat.accept ? OP_SHIFT_STEP : OP_BISECT;
            ST_FINISH: o_cmd.op = OP_FINISH;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
            r_phase <= PH_IDLE;
            r_sel <= SEL_TOL;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_sel <= n_sel;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_m_tvalid = r_m_tvalid;

    `BRF_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, out_issue && r_m_tvalid, i_m_tready, "result overwritten before it was taken")
    `BRF_ASSERT_IMPLIES(a_mul_done_expected, i_clk, i_rst_n, i_stat.mul_done, r_state == ST_MUL_WAIT, "multiplier finished outside its wait state")
    `BRF_ASSERT_IMPLIES(a_div_done_expected, i_clk, i_rst_n, i_stat.div_done, r_state == ST_DIV_WAIT, "divider finished outside its wait state")
    `BRF_ASSERT_ALWAYS(a_no_accept_busy, i_clk, i_rst_n, !(o_s_tready && r_state != ST_WAIT), "input taken while an iteration runs")
endmodule

// ===== src/brent_root_finder_unit.sv =====
// Sequence: a start or the first function value moves to an output state on acceptance, which
// registers its request once the output is free. A later function value runs one iteration,
// shortest on the bisection path, longer on an accepted secant step and longest with inverse
// quadratic interpolation; the serial divider, one quotient bit per cycle, dominates it.
// One item is in work at a time. Synchronous active-low reset idles the search and
// restores tolerance 4295 and max_iterations 200.
module brent_root_finder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [191:0]  i_s_axis_tdata,  // low_end, high_end, function_value
    input  logic          i_s_axis_tuser,  // kind
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,  // point
    output logic [1:0]    o_m_axis_tuser,  // finished, found
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    import brf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  finished;
    logic  found;
    t_word point;

    assign o_cfg_ready = 1'b1;

    brf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_low_end        (i_s_axis_tdata[63:0]),
        .i_high_end       (i_s_axis_tdata[127:64]),
        .i_function_value (i_s_axis_tdata[191:128]),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_finished       (finished),
        .o_point          (point),
        .o_found          (found)
    );

    assign o_m_axis_tdata = point;
    assign o_m_axis_tuser = {found, finished};
endmodule
